/* design/vdpf_pkg.sv */
// ---------------------------------------------------------------------------
// vdpf_pkg
// shared constants, state codes and types of the vertex disjoint path unit
// ---------------------------------------------------------------------------
package vdpf_pkg;

  localparam int NODES   = 64;
  localparam int SPLIT   = 2 * NODES;
  localparam int NODE_W  = $clog2(NODES);
  localparam int SNODE_W = $clog2(SPLIT);
  localparam int CNT_W   = 8;
  localparam int GRP_W   = 8;
  localparam int GROUPS  = SPLIT / GRP_W;
  localparam int GSEL_W  = $clog2(GROUPS);
  localparam int BSEL_W  = $clog2(GRP_W);

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_ADD_WR = 16'h0002,
    S_RB_RD  = 16'h0004,
    S_RB_OUT = 16'h0008,
    S_RB_IN  = 16'h0010,
    S_INIT   = 16'h0020,
    S_DEQ    = 16'h0040,
    S_Q_WT   = 16'h0080,
    S_ROW    = 16'h0100,
    S_SCAN   = 16'h0200,
    S_P_RD   = 16'h0400,
    S_P_WT   = 16'h0800,
    S_R_PAR  = 16'h1000,
    S_R_CUR  = 16'h2000,
    S_DONE   = 16'h4000
  } state_t;

  // lowest pending neighbor of the row being scanned
  typedef struct packed {
    logic               any;
    logic [SNODE_W-1:0] idx;
  } pick_t;

  // loaded row of vertex u to the out-node row: arc u->v lands on in node 2v
  function automatic logic [SPLIT-1:0] spread_row(input logic [NODES-1:0] d);
    logic [SPLIT-1:0] r;
    r = '0;
    for (int v = 0; v < NODES; v++) begin
      r[2*v] = d[v];
    end
    return r;
  endfunction

endpackage

/* design/vdpf_ram.sv */
// ---------------------------------------------------------------------------
// vdpf_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module vdpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/vdpf_pick.sv */
// ---------------------------------------------------------------------------
// vdpf_pick
// two level priority pick of the lowest set bit of the pending row
// ---------------------------------------------------------------------------
module vdpf_pick import vdpf_pkg::*; (
  input  logic [SPLIT-1:0] mask,
  output pick_t            pick
);

  logic [GROUPS-1:0] gany;
  logic [GSEL_W-1:0] gsel;
  logic [BSEL_W-1:0] bsel;
  logic [GRP_W-1:0]  gbits;
  logic              gfound;
  logic              bfound;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      gany[g] = |mask[g*GRP_W +: GRP_W];
    end
    gsel   = '0;
    gfound = 1'b0;
    for (int g = 0; g < GROUPS; g++) begin
      if (gany[g] && !gfound) begin
        gsel   = GSEL_W'(g);
        gfound = 1'b1;
      end
    end
    gbits  = mask[gsel*GRP_W +: GRP_W];
    bsel   = '0;
    bfound = 1'b0;
    for (int b = 0; b < GRP_W; b++) begin
      if (gbits[b] && !bfound) begin
        bsel   = BSEL_W'(b);
        bfound = 1'b1;
      end
    end
    pick.any = gfound;
    pick.idx = {gsel, bsel};
  end

endmodule

/* design/vertex_disjoint_path_flow_top.sv */
// ---------------------------------------------------------------------------
// vertex_disjoint_path_flow_top
// vertex disjoint path counter: unit capacity max flow over split vertices
// ---------------------------------------------------------------------------
// channel  | handshake            | payload
// in       | in_valid / in_ready  | func, edge_from, edge_to, source_node,
//          |                      | sink_node, flow_limit
// out      | out_valid / out_ready| path_count
//
// an add-edge transfer does a read of the loaded row, then a write back
// a query first rebuilds the residual rows from the loaded rows vertex by vertex
// (read, out row write, in row write), then runs one search per path; each
// search dequeues nodes and scans their rows for new ones, and each path reversal
// walks the parent links; both share the single read port of the residual ram
// synchronous reset clears control state and the loaded row valid bits; no
// clearing pass. a finished result waits in the output register; a query that
// completes while it is still untaken holds until the register frees up
// ---------------------------------------------------------------------------
module vertex_disjoint_path_flow_top import vdpf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [NODE_W-1:0]  edge_from,
  input  logic [NODE_W-1:0]  edge_to,
  input  logic [SNODE_W-1:0] source_node,
  input  logic [SNODE_W-1:0] sink_node,
  input  logic [CNT_W-1:0]   flow_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CNT_W-1:0]   path_count
);

  state_t state;

  // latched item
  logic [NODE_W-1:0]  from_q;
  logic [NODE_W-1:0]  to_q;
  logic [SNODE_W-1:0] src_q;
  logic [SNODE_W-1:0] dst_q;
  logic [CNT_W-1:0]   limit_q;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  // search state
  logic [NODE_W-1:0]  u;
  logic [SNODE_W:0]   head;
  logic [SNODE_W:0]   tail;
  logic [SNODE_W-1:0] cur;
  logic [SNODE_W-1:0] par;
  logic [SPLIT-1:0]   pending;
  logic [SPLIT-1:0]   visited;
  logic [NODES-1:0]   ld_vld;

  // ram ports
  logic               ld_we;
  logic [NODE_W-1:0]  ld_waddr;
  logic [NODES-1:0]   ld_wdata;
  logic [NODE_W-1:0]  ld_raddr;
  logic [NODES-1:0]   ld_rdata;
  logic               rs_we;
  logic [SNODE_W-1:0] rs_waddr;
  logic [SPLIT-1:0]   rs_wdata;
  logic [SNODE_W-1:0] rs_raddr;
  logic [SPLIT-1:0]   rs_rdata;
  logic               pa_we;
  logic [SNODE_W-1:0] pa_rdata;
  logic               q_we;
  logic [SNODE_W-1:0] q_waddr;
  logic [SNODE_W-1:0] q_wdata;
  logic [SNODE_W-1:0] q_rdata;
  logic [NODES-1:0]   ld_row;
  logic               slot_free;

  pick_t pk;

  assign in_ready   = (state == S_IDLE);
  assign slot_free  = !out_valid || out_ready;
  assign count_next = count + CNT_W'(1);
  // a row never written since reset reads as no arcs
  assign ld_row     = ld_vld[u] ? ld_rdata : '0;

  vdpf_pick u_pick (
    .mask (pending),
    .pick (pk)
  );

  // loaded arcs, one row per original vertex
  vdpf_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_loaded (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_waddr),
    .wdata (ld_wdata),
    .raddr (ld_raddr),
    .rdata (ld_rdata)
  );

  // residual arcs over split nodes
  vdpf_ram #(.WIDTH(SPLIT), .DEPTH(SPLIT)) u_resid (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  // parent links of the search tree
  vdpf_ram #(.WIDTH(SNODE_W), .DEPTH(SPLIT)) u_parent (
    .clk   (clk),
    .we    (pa_we),
    .waddr (pk.idx),
    .wdata (cur),
    .raddr (cur),
    .rdata (pa_rdata)
  );

  // breadth-first queue
  vdpf_ram #(.WIDTH(SNODE_W), .DEPTH(SPLIT)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head[SNODE_W-1:0]),
    .rdata (q_rdata)
  );

  // ram port steering
  always_comb begin
    ld_raddr = (state == S_IDLE) ? edge_from : u;
    ld_we    = (state == S_ADD_WR);
    ld_waddr = from_q;
    ld_wdata = (ld_vld[from_q] ? ld_rdata : '0) | (NODES'(1) << to_q);

    rs_raddr = cur;
    case (state)
      S_Q_WT:  rs_raddr = q_rdata;
      S_P_WT:  rs_raddr = pa_rdata;
      default: rs_raddr = cur;
    endcase

    rs_we    = 1'b0;
    rs_waddr = cur;
    rs_wdata = rs_rdata;
    case (state)
      S_RB_OUT: begin
        rs_we    = 1'b1;
        rs_waddr = {u, 1'b1};
        rs_wdata = spread_row(ld_row);
      end
      S_RB_IN: begin
        // only the in->out arc leaves an in node
        rs_we    = 1'b1;
        rs_waddr = {u, 1'b0};
        rs_wdata = SPLIT'(1) << {u, 1'b1};
      end
      S_R_PAR: begin
        rs_we    = 1'b1;
        rs_waddr = par;
        rs_wdata = rs_rdata & ~(SPLIT'(1) << cur);
      end
      S_R_CUR: begin
        rs_we    = 1'b1;
        rs_waddr = cur;
        rs_wdata = rs_rdata | (SPLIT'(1) << par);
      end
      default: rs_we = 1'b0;
    endcase

    pa_we   = (state == S_SCAN) && pk.any;
    q_we    = (state == S_INIT) || ((state == S_SCAN) && pk.any);
    q_waddr = (state == S_INIT) ? '0 : tail[SNODE_W-1:0];
    q_wdata = (state == S_INIT) ? src_q : pk.idx;
  end

  // output register: loaded by a finished query, emptied by its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ld_vld    <= '0;
      count     <= '0;
      u         <= '0;
      head      <= '0;
      tail      <= '0;
      visited   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            from_q  <= edge_from;
            to_q    <= edge_to;
            src_q   <= source_node;
            dst_q   <= sink_node;
            limit_q <= flow_limit;
            count   <= '0;
            u       <= '0;
            if (func == FUNC_ADD) begin
              state <= S_ADD_WR;
            end else if (source_node == sink_node || flow_limit == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_RB_RD;
            end
          end
        end
        S_ADD_WR: begin
          ld_vld[from_q] <= 1'b1;
          state          <= S_IDLE;
        end
        S_RB_RD:  state <= S_RB_OUT;
        S_RB_OUT: state <= S_RB_IN;
        S_RB_IN: begin
          u <= u + NODE_W'(1);
          if (u == NODE_W'(NODES - 1)) begin
            state <= S_INIT;
          end else begin
            state <= S_RB_RD;
          end
        end
        S_INIT: begin
          visited <= SPLIT'(1) << src_q;
          head    <= '0;
          tail    <= (SNODE_W+1)'(1);
          state   <= S_DEQ;
        end
        S_DEQ: begin
          if (visited[dst_q]) begin
            cur   <= dst_q;
            state <= S_P_RD;
          end else if (head != tail) begin
            head  <= head + (SNODE_W+1)'(1);
            state <= S_Q_WT;
          end else begin
            state <= S_DONE;
          end
        end
        S_Q_WT: begin
          cur   <= q_rdata;
          state <= S_ROW;
        end
        S_ROW: begin
          pending <= rs_rdata & ~visited;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (pk.any) begin
            visited[pk.idx] <= 1'b1;
            pending[pk.idx] <= 1'b0;
            tail            <= tail + (SNODE_W+1)'(1);
          end else begin
            state <= S_DEQ;
          end
        end
        S_P_RD: state <= S_P_WT;
        S_P_WT: begin
          par   <= pa_rdata;
          state <= S_R_PAR;
        end
        S_R_PAR: state <= S_R_CUR;
        S_R_CUR: begin
          cur <= par;
          if (par == src_q) begin
            count <= count_next;
            state <= (count_next < limit_q) ? S_INIT : S_DONE;
          end else begin
            state <= S_P_RD;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            path_count <= count;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // count stays within the limit for the whole query
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_ADD_WR) |-> count <= limit_q)
    else $error("path count passed limit");

  // queue pointers stay ordered and bounded
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEQ || state == S_SCAN) |-> (head <= tail && tail <= (SNODE_W+1)'(SPLIT)))
    else $error("queue pointer out of order");

  // a picked neighbor was not yet visited
  a_pick_fresh: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && pk.any) |-> !visited[pk.idx])
    else $error("visited node picked again");

  // the source stays marked throughout a search
  a_src_mark: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEQ || state == S_ROW) |-> visited[src_q])
    else $error("source lost its mark");

  // a result is only loaded into a free output register
  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !slot_free) |=> state == S_DONE)
    else $error("result overwritten");

endmodule

/* tb/tb_vertex_disjoint_path_flow_top.sv */
// ---------------------------------------------------------------------------
// tb_vertex_disjoint_path_flow_top
// self-checking bench for the vertex disjoint path counter: arc loads and
// flow queries go through a shadow graph, each query answer is predicted by
// repeated breadth-first augmentation and checked against the output
// ---------------------------------------------------------------------------
module tb_vertex_disjoint_path_flow_top;
  import vdpf_pkg::*;

  localparam int CYCLE_LIMIT = 30000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               func = FUNC_ADD;
  logic [NODE_W-1:0]  edge_from = '0;
  logic [NODE_W-1:0]  edge_to = '0;
  logic [SNODE_W-1:0] source_node = '0;
  logic [SNODE_W-1:0] sink_node = '0;
  logic [CNT_W-1:0]   flow_limit = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CNT_W-1:0]   path_count;

  // shadow of the loaded arcs and the residual graph used while predicting
  logic [NODES-1:0] shadow_arcs [NODES];
  logic [SPLIT-1:0] shadow_res [SPLIT];

  logic [CNT_W-1:0] expected_counts [$];
  int               errors = 0;
  int               cycles = 0;
  int               arcs_sent = 0;
  int               queries_sent = 0;
  int               answers_checked = 0;
  int               hold_left = 0;
  int               hold_asks = 0;
  int               hold_seen = 0;
  int               max_gap = 3;

  vertex_disjoint_path_flow_top DUT (.*);

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers pending", cycles,
               expected_counts.size());
      $display("** vertex_disjoint_path_flow_top: FAILED **");
      $finish;
    end
  end

  // split residual graph: in->out for every vertex, out(u)->in(v) for arcs
  task automatic build_residual();
    for (int u = 0; u < NODES; u++) begin
      shadow_res[2*u]   = '0;
      shadow_res[2*u+1] = '0;
    end
    for (int u = 0; u < NODES; u++) begin
      shadow_res[2*u][2*u+1] = 1'b1;
      for (int v = 0; v < NODES; v++) begin
        if (shadow_arcs[u][v]) shadow_res[2*u+1][2*v] = 1'b1;
      end
    end
  endtask

  // augment one path by bfs in index order; returns 0 when the sink is cut off
  function automatic bit augment_once(int src, int dst);
    logic [SPLIT-1:0] seen;
    int               parent [SPLIT];
    int               fifo [SPLIT];
    int               head;
    int               tail;
    int               cur;
    int               par;
    int               steps;
    seen = '0;
    head = 0;
    tail = 0;
    seen[src] = 1'b1;
    fifo[tail++] = src;
    while (head < tail && !seen[dst]) begin
      cur = fifo[head++];
      for (int n = 0; n < SPLIT; n++) begin
        if (shadow_res[cur][n] && !seen[n]) begin
          seen[n] = 1'b1;
          parent[n] = cur;
          if (tail < SPLIT) fifo[tail++] = n;
        end
      end
    end
    if (!seen[dst]) return 1'b0;
    // flip arcs along the path; an opposing arc simply merges
    cur = dst;
    steps = 0;
    while (cur != src && steps < SPLIT) begin
      par = parent[cur];
      shadow_res[par][cur] = 1'b0;
      shadow_res[cur][par] = 1'b1;
      cur = par;
      steps++;
    end
    return 1'b1;
  endfunction

  task automatic predict_paths(int src, int dst, int limit, output logic [CNT_W-1:0] n);
    int found;
    found = 0;
    if (src != dst) begin
      build_residual();
      while (found < limit && augment_once(src, dst)) found++;
    end
    n = found[CNT_W-1:0];
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 40);
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, max_gap);
  endfunction

  // one input transfer; valid only drops when a gap comes before it
  task automatic send_item(logic f, int a, int b, int s, int d, int lim);
    int               gap;
    logic [CNT_W-1:0] want;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    edge_from   <= a[NODE_W-1:0];
    edge_to     <= b[NODE_W-1:0];
    source_node <= s[SNODE_W-1:0];
    sink_node   <= d[SNODE_W-1:0];
    flow_limit  <= lim[CNT_W-1:0];
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (f == FUNC_ADD) begin
      shadow_arcs[a][b] = 1'b1;
      arcs_sent++;
    end else begin
      predict_paths(s, d, lim, want);
      expected_counts.push_back(want);
      queries_sent++;
    end
  endtask

  task automatic add_arc(int a, int b);
    send_item(FUNC_ADD, a, b, $urandom_range(0, SPLIT-1), $urandom_range(0, SPLIT-1),
              $urandom_range(0, 128));
  endtask

  task automatic ask_flow(int s, int d, int lim);
    send_item(FUNC_QUERY, $urandom_range(0, NODES-1), $urandom_range(0, NODES-1), s, d, lim);
  endtask

  // sender stops and waits for every answer, plus the add-edge write-back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // receiver: random stalls, or a counted long hold-off when requested
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      out_ready <= 1'b0;
      hold_left <= 3000;
      hold_seen <= hold_asks;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 19) == 0) begin
      out_ready <= 1'b0;
      hold_left <= $urandom_range(5, 60);
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // output check, sampled mid-cycle ahead of the transferring edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        report_mismatch("unexpected answer", path_count, -1);
      end else begin
        if (path_count !== expected_counts[0])
          report_mismatch("path_count", path_count, expected_counts[0]);
        void'(expected_counts.pop_front());
        answers_checked++;
      end
    end
  end

  // extremes of the node fields, self loops, merged reverse arcs, zero limits and limits of 128
  task automatic test_directed();
    ask_flow(1, 0, 5);            // empty graph: out(0) cannot reach in(0)
    ask_flow(0, 1, 128);          // the in->out arc alone gives one path
    add_arc(0, 63);
    add_arc(63, 0);               // opposing pair, merges under reversal
    add_arc(0, 63);               // duplicate collapses
    add_arc(0, 1);
    add_arc(1, 63);
    add_arc(0, 2);
    add_arc(2, 63);
    add_arc(5, 5);                // self loop
    ask_flow(1, 126, 128);        // three disjoint routes into vertex 63
    ask_flow(1, 126, 2);          // limit cuts it short
    ask_flow(1, 126, 0);          // zero limit
    ask_flow(77, 77, 128);        // source equals sink
    ask_flow(127, 0, 128);        // out(63) -> in(0)
    ask_flow(0, 127, 128);        // whole-vertex route through the chain
    ask_flow(11, 10, 9);          // self loop on vertex 5
    add_arc(42, 21);
    add_arc(21, 42);
    ask_flow(85, 84, 1);
    drain();
  endtask

  // answers blocked for a long stretch while queries keep coming
  task automatic test_backpressure();
    @(posedge clk);
    hold_asks++;
    for (int i = 0; i < 6; i++) ask_flow(2*$urandom_range(0, 7)+1, 2*$urandom_range(0, 7), 128);
    drain();
  endtask

  // mostly dense small graphs with out->in queries, a sprinkling of anything goes
  task automatic test_random();
    int s;
    int d;
    for (int i = 0; i < 75; i++) begin
      max_gap = (i < 40) ? 3 : 0;
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 5) == 0) add_arc($urandom_range(0, 63), $urandom_range(0, 63));
        else add_arc($urandom_range(0, 15), $urandom_range(0, 15));
      end else if ($urandom_range(0, 4) == 0) begin
        ask_flow($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 128));
      end else begin
        s = 2*$urandom_range(0, 15) + 1;
        d = 2*$urandom_range(0, 15);
        ask_flow(s, d, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 128);
      end
    end
    drain();
  endtask

  initial begin
    for (int u = 0; u < NODES; u++) shadow_arcs[u] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    repeat (20) @(posedge clk);
    $display("covered %0d arc loads and %0d flow queries, %0d answers compared",
             arcs_sent, queries_sent, answers_checked);
    $display("including a 3000-cycle output stall and drained pauses between phases");
    if (errors == 0 && expected_counts.size() == 0) begin
      $display("** vertex_disjoint_path_flow_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d answers missing", errors, expected_counts.size());
      $display("** vertex_disjoint_path_flow_top: FAILED **");
    end
    $finish;
  end

endmodule

/* vertex_disjoint_path_flow_top.f */
design/vdpf_pkg.sv
design/vdpf_ram.sv
design/vdpf_pick.sv
design/vertex_disjoint_path_flow_top.sv
tb/tb_vertex_disjoint_path_flow_top.sv
